// ----- hdl/laser_scan_to_pixel_macros.svh -----
// Assertion macros shared by the RTL of the scan-to-pixel block.
// Define ASSERT_OFF to compile every check away.
`ifndef LASER_SCAN_TO_PIXEL_MACROS_SVH
`define LASER_SCAN_TO_PIXEL_MACROS_SVH

`ifndef ASSERT_OFF

`define LSTP_ASSERT_IMPLY(label, clk_s, rst_s, pre, post, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (pre) |-> (post)) \
    else $error(msg);

`define LSTP_ASSERT_NEXT(label, clk_s, rst_s, pre, post, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (pre) |=> (post)) \
    else $error(msg);

`else

`define LSTP_ASSERT_IMPLY(label, clk_s, rst_s, pre, post, msg)

`define LSTP_ASSERT_NEXT(label, clk_s, rst_s, pre, post, msg)

`endif

`endif

// ----- hdl/lstp_pkg.sv -----
`default_nettype none

package lstp_pkg;

  // Image geometry.
  localparam int IMAGE_SIZE = 512;
  localparam int HALF       = IMAGE_SIZE / 2;
  localparam int HALF_W     = $clog2(HALF + 1);
  localparam int QW         = $clog2(HALF);
  localparam int PW         = $clog2(IMAGE_SIZE);

  // CORDIC datapath: x and y in Q4.30, z in 2^32-per-turn units.
  localparam int CORDIC_STEPS = 16;
  localparam int XW           = 34;
  localparam int ZW           = 33;

  localparam logic signed [XW-1:0] CORDIC_X0 = XW'(652032874);
  localparam logic signed [XW-1:0] Q15_ROUND = XW'(16384);
  localparam logic signed [XW-1:0] Q_HI      = XW'(32767);
  localparam logic signed [XW-1:0] Q_LO      = -Q_HI;
  localparam logic signed [15:0]   TRIG_MAX  = 16'sd32767;

  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  // Divider: range * |trig| * HALF over range_max * 2^15.
  localparam int PROD_W    = 31;
  localparam int DEN_SHIFT = 15;
  localparam int NUM_W     = PROD_W + HALF_W;

  // Pipeline bookkeeping: one valid bit per stage before the output register.
  localparam int V_TRIG = CORDIC_STEPS + 2;
  localparam int NV     = V_TRIG + 3 + QW;
  localparam int NSTAGE = NV + 1;

  // Register defaults.
  localparam logic [15:0] RANGE_MIN_RST  = 16'h0000;
  localparam logic [15:0] RANGE_MAX_RST  = 16'hFFFF;
  localparam logic [15:0] ANGLE_MIN_RST  = 16'h8000;
  localparam logic [15:0] ANGLE_STEP_RST = 16'd182;

  typedef enum logic [1:0] {
    REG_RANGE_MIN  = 2'd0,
    REG_RANGE_MAX  = 2'd1,
    REG_ANGLE_MIN  = 2'd2,
    REG_ANGLE_STEP = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] range;
    logic [11:0] sample_index;
  } in_item_t;

  typedef struct packed {
    logic [8:0] pixel_x;
    logic [8:0] pixel_y;
    logic       hit;
  } out_item_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [1:0]           quad;
    logic [15:0]          range;
    logic                 ok;
  } cord_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem_x;
    logic [NUM_W-1:0] rem_y;
    logic [QW-1:0]    q_x;
    logic [QW-1:0]    q_y;
    logic             neg_x;
    logic             neg_y;
    logic             ok;
  } div_t;

endpackage

`default_nettype wire

// ----- hdl/laser_scan_to_pixel.sv -----
// Channel | Ports                           | Handshake
// --------+---------------------------------+--------------------------------------
// input   | start, busy, scan_item          | item taken at an edge with start & !busy
// config  | cfg_we, cfg_index, cfg_data     | register written at an edge with cfg_we
// result  | done, result                    | done high one cycle, cannot be held off
//
// A new item may enter every cycle; it passes through entry and angle, CORDIC setup,
// 16 CORDIC stages, Q1.15 rounding, the range product, the dividend, one stage per
// quotient bit, and the output register. Reset is synchronous, loads the register
// defaults and clears the stage valid bits and done; busy is high only during reset.
// Nothing inside ever stalls, as the receiver takes every result.
`default_nettype none

`include "laser_scan_to_pixel_macros.svh"

module laser_scan_to_pixel (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire lstp_pkg::in_item_t   scan_item,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [15:0]          cfg_data,
  output logic                      done,
  output lstp_pkg::out_item_t       result
);

  function automatic logic signed [15:0] to_q15(input logic signed [lstp_pkg::XW-1:0] v);
    logic signed [lstp_pkg::XW-1:0] t;
    t = (v + lstp_pkg::Q15_ROUND) >>> 15;
    if (t > lstp_pkg::Q_HI) begin
      return lstp_pkg::TRIG_MAX;
    end else if (t < lstp_pkg::Q_LO) begin
      return -lstp_pkg::TRIG_MAX;
    end
    return 16'(t);
  endfunction

  logic [15:0] min_range;
  logic [15:0] max_range;
  logic [15:0] base_angle;
  logic [15:0] angle_step;

  logic                   accept;
  logic [lstp_pkg::NV-1:0] vld;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_range  <= lstp_pkg::RANGE_MIN_RST;
      max_range  <= lstp_pkg::RANGE_MAX_RST;
      base_angle <= lstp_pkg::ANGLE_MIN_RST;
      angle_step <= lstp_pkg::ANGLE_STEP_RST;
    end else if (cfg_we) begin
      unique case (lstp_pkg::cfg_reg_t'(cfg_index))
        lstp_pkg::REG_RANGE_MIN:  min_range  <= cfg_data;
        lstp_pkg::REG_RANGE_MAX:  max_range  <= cfg_data;
        lstp_pkg::REG_ANGLE_MIN:  base_angle <= cfg_data;
        lstp_pkg::REG_ANGLE_STEP: angle_step <= cfg_data;
        default:                  min_range  <= min_range;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[lstp_pkg::NV-2:0], accept};
      done <= vld[lstp_pkg::NV-1];
    end
  end

  // Entry: beam angle modulo one turn and the range window check.
  logic [27:0] idx_prod;
  logic [15:0] ent_angle;
  logic [15:0] ent_range;
  logic        ent_ok;

  assign idx_prod = scan_item.sample_index * angle_step;

  always_ff @(posedge clk) begin
    ent_angle <= base_angle + idx_prod[15:0];
    ent_range <= scan_item.range;
    ent_ok    <= (max_range != '0) && (scan_item.range >= min_range) &&
                 (scan_item.range <= max_range);
  end

  // CORDIC setup: fold the angle into a quadrant and a residual of at most 1/8 turn.
  logic [15:0] ang_bias;
  logic [1:0]  quad;
  logic [15:0] resid;
  lstp_pkg::cord_t cord [lstp_pkg::CORDIC_STEPS+1];

  assign ang_bias = ent_angle + 16'h2000;
  assign quad     = ang_bias[15:14];
  assign resid    = ent_angle - {quad, 14'b0};

  always_ff @(posedge clk) begin
    cord[0].x     <= lstp_pkg::CORDIC_X0;
    cord[0].y     <= '0;
    cord[0].z     <= {{(lstp_pkg::ZW-32){resid[15]}}, resid, 16'h0000};
    cord[0].quad  <= quad;
    cord[0].range <= ent_range;
    cord[0].ok    <= ent_ok;
  end

  for (genvar i = 0; i < lstp_pkg::CORDIC_STEPS; i++) begin : g_cordic
    logic signed [lstp_pkg::XW-1:0] dx;
    logic signed [lstp_pkg::XW-1:0] dy;
    logic signed [lstp_pkg::ZW-1:0] at;
    lstp_pkg::cord_t                stage_next;

    assign dx = cord[i].y >>> i;
    assign dy = cord[i].x >>> i;
    assign at = lstp_pkg::ZW'(lstp_pkg::ATAN_TURNS[i]);

    always_comb begin
      stage_next = cord[i];
      if (!cord[i].z[lstp_pkg::ZW-1]) begin
        stage_next.x = cord[i].x - dx;
        stage_next.y = cord[i].y + dy;
        stage_next.z = cord[i].z - at;
      end else begin
        stage_next.x = cord[i].x + dx;
        stage_next.y = cord[i].y - dy;
        stage_next.z = cord[i].z + at;
      end
    end

    always_ff @(posedge clk) begin
      cord[i+1] <= stage_next;
    end
  end

  // Round to Q1.15 and rotate back by whole quarter turns.
  logic signed [15:0] xq;
  logic signed [15:0] yq;
  logic signed [15:0] rot_c;
  logic signed [15:0] rot_s;
  logic signed [15:0] trig_c;
  logic signed [15:0] trig_s;
  logic [15:0]        trig_range;
  logic               trig_ok;

  assign xq = to_q15(cord[lstp_pkg::CORDIC_STEPS].x);
  assign yq = to_q15(cord[lstp_pkg::CORDIC_STEPS].y);

  always_comb begin
    case (cord[lstp_pkg::CORDIC_STEPS].quad)
      2'd0: begin
        rot_c = xq;
        rot_s = yq;
      end
      2'd1: begin
        rot_c = -yq;
        rot_s = xq;
      end
      2'd2: begin
        rot_c = -xq;
        rot_s = -yq;
      end
      default: begin
        rot_c = yq;
        rot_s = -xq;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    trig_c     <= rot_c;
    trig_s     <= rot_s;
    trig_range <= cord[lstp_pkg::CORDIC_STEPS].range;
    trig_ok    <= cord[lstp_pkg::CORDIC_STEPS].ok;
  end

  // Magnitude product; the sign is applied after the division so it truncates toward zero.
  logic [14:0]                 abs_c;
  logic [14:0]                 abs_s;
  logic [lstp_pkg::PROD_W-1:0] prod_x;
  logic [lstp_pkg::PROD_W-1:0] prod_y;
  logic                        prod_neg_x;
  logic                        prod_neg_y;
  logic                        prod_ok;

  assign abs_c = trig_c[15] ? 15'(-trig_c) : 15'(trig_c);
  assign abs_s = trig_s[15] ? 15'(-trig_s) : 15'(trig_s);

  always_ff @(posedge clk) begin
    prod_x     <= trig_range * abs_c;
    prod_y     <= trig_range * abs_s;
    prod_neg_x <= trig_c[15];
    prod_neg_y <= trig_s[15];
    prod_ok    <= trig_ok;
  end

  // Restoring division, one quotient bit per stage. With range at most max_range the
  // quotient stays below HALF, so QW bits hold it and the pixel always lands on the image.
  lstp_pkg::div_t             div [lstp_pkg::QW+1];
  logic [lstp_pkg::NUM_W-1:0] den;

  assign den = lstp_pkg::NUM_W'({max_range, {lstp_pkg::DEN_SHIFT{1'b0}}});

  always_ff @(posedge clk) begin
    div[0].rem_x <= prod_x * lstp_pkg::NUM_W'(lstp_pkg::HALF);
    div[0].rem_y <= prod_y * lstp_pkg::NUM_W'(lstp_pkg::HALF);
    div[0].q_x   <= '0;
    div[0].q_y   <= '0;
    div[0].neg_x <= prod_neg_x;
    div[0].neg_y <= prod_neg_y;
    div[0].ok    <= prod_ok;
  end

  for (genvar j = 0; j < lstp_pkg::QW; j++) begin : g_div
    localparam int B = lstp_pkg::QW - 1 - j;
    logic [lstp_pkg::NUM_W-1:0] trial;
    lstp_pkg::div_t             stage_next;

    assign trial = den << B;

    always_comb begin
      stage_next = div[j];
      if (div[j].rem_x >= trial) begin
        stage_next.rem_x  = div[j].rem_x - trial;
        stage_next.q_x[B] = 1'b1;
      end
      if (div[j].rem_y >= trial) begin
        stage_next.rem_y  = div[j].rem_y - trial;
        stage_next.q_y[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      div[j+1] <= stage_next;
    end
  end

  // Offset by half the image and register the result item, with zero pixels on a miss.
  logic [lstp_pkg::PW-1:0] px;
  logic [lstp_pkg::PW-1:0] py;

  assign px = div[lstp_pkg::QW].neg_x ?
              lstp_pkg::PW'(lstp_pkg::HALF) - lstp_pkg::PW'(div[lstp_pkg::QW].q_x) :
              lstp_pkg::PW'(lstp_pkg::HALF) + lstp_pkg::PW'(div[lstp_pkg::QW].q_x);
  assign py = div[lstp_pkg::QW].neg_y ?
              lstp_pkg::PW'(lstp_pkg::HALF) - lstp_pkg::PW'(div[lstp_pkg::QW].q_y) :
              lstp_pkg::PW'(lstp_pkg::HALF) + lstp_pkg::PW'(div[lstp_pkg::QW].q_y);

  always_ff @(posedge clk) begin
    result.pixel_x <= div[lstp_pkg::QW].ok ? 9'(px) : '0;
    result.pixel_y <= div[lstp_pkg::QW].ok ? 9'(py) : '0;
    result.hit     <= div[lstp_pkg::QW].ok;
  end

  `LSTP_ASSERT_IMPLY(a_done_latency, clk, rst, done, $past(start && !busy, lstp_pkg::NSTAGE), "result without a matching item")
  `LSTP_ASSERT_IMPLY(a_miss_zero, clk, rst, done && !result.hit, result.pixel_x == '0 && result.pixel_y == '0, "missed return carries a pixel")
  `LSTP_ASSERT_IMPLY(a_trig_clamp, clk, rst, vld[lstp_pkg::V_TRIG], !(trig_c[15] && trig_c[14:0] == '0) && !(trig_s[15] && trig_s[14:0] == '0), "trig value escaped its clamp")
  `LSTP_ASSERT_NEXT(a_zero_scale, clk, rst, accept && max_range == '0, !ent_ok, "zero full-scale range let an item through")

endmodule

`default_nettype wire
